[rtl/core/soc_pkg.sv]
// soc_pkg: shared types and constants for the subsequence occurrence counter
// used by soc_cfg, soc_cell and the top level; no dependencies
package soc_pkg;

    localparam int PATTERN_SLOTS   = 16;
    localparam int MAX_PATTERN_DEF = 16;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int LEN_W           = 5;
    localparam int CHAR_W          = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int OUT_COUNT_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LEN = 2'd0,
        REG_PATTERN_LO  = 2'd1,
        REG_PATTERN_HI  = 2'd2
    } soc_reg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]                     pattern_len;
        logic [PATTERN_SLOTS-1:0][CHAR_W-1:0] pattern_chars;
    } soc_cfg_t;

    // broadcast to every cell on an accepted text beat
    typedef struct packed {
        logic              step;
        logic              last;
        logic [CHAR_W-1:0] text_char;
    } soc_step_t;

endpackage

[rtl/core/soc_cfg.sv]
// soc_cfg: pattern length and pattern character registers
// depends on soc_pkg
module soc_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [soc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [soc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output soc_pkg::soc_cfg_t                   cfg
);

    logic [soc_pkg::LEN_W-1:0]      len_reg;
    logic [soc_pkg::CFG_DATA_W-1:0] lo_reg;
    logic [soc_pkg::CFG_DATA_W-1:0] hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (soc_pkg::soc_reg_idx_t'(cfg_index))
                soc_pkg::REG_PATTERN_LEN: len_reg <= cfg_data[soc_pkg::LEN_W-1:0];
                soc_pkg::REG_PATTERN_LO:  lo_reg  <= cfg_data;
                soc_pkg::REG_PATTERN_HI:  hi_reg  <= cfg_data;
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign cfg.pattern_len   = len_reg;
    assign cfg.pattern_chars = {hi_reg, lo_reg};

endmodule

[rtl/core/soc_cell.sv]
// soc_cell: one prefix count of the chain with its saturating adder
// depends on soc_pkg
module soc_cell #(
    parameter int COUNT_BITS = soc_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  soc_pkg::soc_step_t            step,
    input  logic                          active,
    input  logic [soc_pkg::CHAR_W-1:0]    pattern_char,
    input  logic [COUNT_BITS-1:0]         count_below,
    output logic [COUNT_BITS-1:0]         count,
    output logic [COUNT_BITS-1:0]         count_next,
    output logic                          clamped
);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS:0]   sum;
    logic                  hit;

    always_comb
    begin
        hit        = active && (step.text_char == pattern_char);
        sum        = {1'b0, count_reg} + {1'b0, count_below};
        clamped    = hit && sum[COUNT_BITS];
        count_next = count_reg;
        if (hit)
        begin
            count_next = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (step.step)
        begin
            // last byte of a text leaves the chain empty for the next one
            count_reg <= step.last ? '0 : count_next;
        end
    end

    assign count = count_reg;

endmodule

[rtl/core/subsequence_occurrence_counter_top.sv]
// subsequence_occurrence_counter_top: subsequence occurrence counter, top level
// depends on soc_pkg, soc_cfg and soc_cell
//
// Counts how often the configured pattern occurs as a subsequence of the
// text streamed in on the slave channel, one text byte per beat.
// s_axis: text bytes; tlast marks the final byte of a text.
// m_axis: one result beat per text beat: running count of the whole
// pattern, sticky saturation flag in tuser, tlast echoing the input tlast.
// cfg: register writes (pattern length, characters 0-7, characters 8-15),
// always ready; write only while no text beat is in flight.
// The result beat is registered and appears in the cycle after its text beat.
// Throughput is one byte per cycle while the receiver keeps up: every cell
// of the prefix chain updates its count in the same cycle with its own
// adder, and the result register frees as soon as the receiver takes the beat.
// If the receiver stalls, the result is held and s_axis_tready drops until
// it is taken; no beat is lost.
// Reset clears the counts, the saturation flag, the registers and the
// result valid flag. The final byte of a text clears the counts after its result.
module subsequence_occurrence_counter_top #(
    parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF,
    parameter int COUNT_BITS  = soc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] text_char
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [31:0] occurrence_count
    output logic                              m_axis_tuser,  // [0] saturated
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [soc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [soc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int WIDE_W = (COUNT_BITS > soc_pkg::OUT_COUNT_W) ? COUNT_BITS
                                                                : soc_pkg::OUT_COUNT_W;

    soc_pkg::soc_cfg_t  cfg;
    soc_pkg::soc_step_t step;

    logic [MAX_PATTERN-1:0][COUNT_BITS-1:0] counts;
    logic [MAX_PATTERN-1:0][COUNT_BITS-1:0] counts_next;
    logic [MAX_PATTERN-1:0]                 clamped;
    logic [MAX_PATTERN-1:0]                 active;

    logic [soc_pkg::LEN_W-1:0] len_eff;
    logic [COUNT_BITS-1:0]     sel_count;
    logic [WIDE_W-1:0]         sel_wide;
    logic                      accept;
    logic                      ovf_next;

    logic                              ovf_reg;
    logic                              out_valid_reg;
    logic [soc_pkg::OUT_COUNT_W-1:0]   out_count_reg;
    logic                              out_sat_reg;
    logic                              out_last_reg;

    soc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign step.step      = accept;
    assign step.last      = s_axis_tlast;
    assign step.text_char = s_axis_tdata;

    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++)
        begin : g_cell
            logic [COUNT_BITS-1:0] below;
            if (g == 0)
            begin : g_head
                // the empty prefix always counts one
                assign below = COUNT_BITS'(1);
            end
            else
            begin : g_link
                assign below = counts[g-1];
            end

            assign active[g] = cfg.pattern_len > soc_pkg::LEN_W'(g);

            soc_cell #(
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .step         (step),
                .active       (active[g]),
                .pattern_char (cfg.pattern_chars[g]),
                .count_below  (below),
                .count        (counts[g]),
                .count_next   (counts_next[g]),
                .clamped      (clamped[g])
            );
        end
    endgenerate

    always_comb
    begin
        len_eff = (cfg.pattern_len > soc_pkg::LEN_W'(MAX_PATTERN))
                  ? soc_pkg::LEN_W'(MAX_PATTERN) : cfg.pattern_len;
        sel_count = COUNT_BITS'(1);
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (len_eff == soc_pkg::LEN_W'(j + 1))
            begin
                sel_count = counts_next[j];
            end
        end
        sel_wide = WIDE_W'(sel_count);
        ovf_next = ovf_reg || (|clamped);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ovf_reg       <= s_axis_tlast ? 1'b0 : ovf_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_count_reg <= sel_wide[soc_pkg::OUT_COUNT_W-1:0];
            out_sat_reg   <= ovf_next;
            out_last_reg  <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_count_reg;
    assign m_axis_tuser  = out_sat_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/core/soc_checker.sv]
// soc_checker: port-level assertions for the subsequence occurrence counter
// bound to subsequence_occurrence_counter_top
module soc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [31:0]                       m_axis_tdata,
    input  logic                              m_axis_tuser,
    input  logic                              m_axis_tlast
);

    // every text beat yields a result beat in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("text beat without result beat");

    // the slave side takes a beat whenever the result stage is free or draining
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow result stage");

    // a taken result with no new text beat leaves nothing behind
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready))
        |=> !m_axis_tvalid)
        else $error("result beat without text beat");

    // a stalled result stays offered with the same contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
        else $error("stalled result withdrawn or changed");

endmodule

bind subsequence_occurrence_counter_top soc_checker u_soc_checker (.*);
